/* sv/nnr_pkg.sv */
// shared types and constants of the nearest neighbor resampler
`timescale 1ns / 1ps

package nnr_pkg;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP  = 2'd1;

  // grid spacing after reset
  localparam int STEP_RESET = 5;

  // controller to datapath
  typedef struct packed {
    logic load_in;   // capture the accepted word
    logic setup;     // first-sample check or run distances
    logic emit_one;  // single-sample stream result
    logic emit_run;  // one grid result of a run
    logic commit;    // hold the word or close the stream
    logic div_go;    // launch the skip remainder
    logic fix;       // place the grid after a cut run
  } nnr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic held_valid;
    logic cur_end;
    logic slot_free;
    logic run_empty;
    logic run_last;
    logic run_cut;
    logic div_busy;
  } nnr_sts_t;

endpackage

/* sv/nnr_in_if.sv */
// sample channel: valid, ready and one timestamped sample
`timescale 1ns / 1ps

interface nnr_in_if #(
  parameter int TIME_BITS    = 32,
  parameter int PAYLOAD_BITS = 64
);
  logic                    valid;
  logic                    ready;
  logic [TIME_BITS-1:0]    sample_time;
  logic [PAYLOAD_BITS-1:0] sample_payload;
  logic                    stream_end;

  modport source (output valid, sample_time, sample_payload, stream_end, input ready);
  modport sink   (input valid, sample_time, sample_payload, stream_end, output ready);
endinterface

/* sv/nnr_out_if.sv */
// result channel: valid, ready and one resampled grid point
`timescale 1ns / 1ps

interface nnr_out_if #(
  parameter int TIME_BITS    = 32,
  parameter int PAYLOAD_BITS = 64
);
  logic                    valid;
  logic                    ready;
  logic [TIME_BITS:0]      grid_time;
  logic [TIME_BITS-1:0]    chosen_time;
  logic [PAYLOAD_BITS-1:0] chosen_payload;
  logic                    run_last;
  logic                    run_cut;
  logic                    early_start;

  modport source (output valid, grid_time, chosen_time, chosen_payload, run_last, run_cut,
                  early_start, input ready);
  modport sink   (input valid, grid_time, chosen_time, chosen_payload, run_last, run_cut,
                  early_start, output ready);
endinterface

/* sv/nearest_neighbor_resampler.sv */
// top level of the nearest neighbor timestamp resampler
//
//   channel  | direction | handshake              | word
//   ---------+-----------+------------------------+------------------------------------
//   in_ch    | in        | valid/ready            | sample_time, sample_payload, end
//   out_ch   | out       | valid/ready            | grid, chosen time/payload, flags
//   cfg_*    | in        | cfg_we, no back-pressure | cfg_idx 0 start_time, 1 step_time
//
// one sample word at a time: the first sample of a stream is only held, or
// sent out as a single result when it also ends the stream; any other word
// serves its grid results, one per cycle while out_ch drains
// a run cut at MAX_RUN adds a serial remainder in nnr_rem
// that places the grid past the sample, unless the stream ends there
// rst_n is synchronous; no clearing pass, the block is ready right after it
// a finished result waits in the output register while the next word is taken
`timescale 1ns / 1ps

module nearest_neighbor_resampler #(
  parameter int TIME_BITS    = 32,
  parameter int PAYLOAD_BITS = 64,
  parameter int MAX_RUN      = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  nnr_in_if.sink                           in_ch,
  nnr_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [nnr_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [TIME_BITS-1:0]             cfg_wdata
);
  nnr_pkg::nnr_cmd_t cmd;
  nnr_pkg::nnr_sts_t sts;
  logic              in_ready;

  // sequencing: idle, distance setup, single result, run emission, remainder skip
  nnr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // held and arriving samples, grid walk, config and the output register
  nnr_dp #(
    .TIME_BITS    (TIME_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .MAX_RUN      (MAX_RUN)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_sample_time     (in_ch.sample_time),
    .in_sample_payload  (in_ch.sample_payload),
    .in_stream_end      (in_ch.stream_end),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_wdata          (cfg_wdata),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_grid_time      (out_ch.grid_time),
    .out_chosen_time    (out_ch.chosen_time),
    .out_chosen_payload (out_ch.chosen_payload),
    .out_run_last       (out_ch.run_last),
    .out_run_cut        (out_ch.run_cut),
    .out_early_start    (out_ch.early_start)
  );

  assign in_ch.ready = in_ready;

endmodule

/* sv/nnr_rem.sv */
// bit-serial restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps

module nnr_rem #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  dvd_r, dvd_nxt;
  logic [W-1:0]  dsr_r, dsr_nxt;
  logic [W:0]    trial;

  assign trial = {acc_r, dvd_r[W-1]} - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // keep the trial difference when it does not borrow
      if (!trial[W]) begin
        acc_nxt = trial[W-1:0];
      end else begin
        acc_nxt = {acc_r[W-2:0], dvd_r[W-1]};
      end
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy = busy_r;
  assign rem  = acc_r;

endmodule

/* sv/nnr_dp.sv */
// resampler datapath: registers, grid walk, nearest choice and result register
`timescale 1ns / 1ps

module nnr_dp #(
  parameter int TIME_BITS    = 32,
  parameter int PAYLOAD_BITS = 64,
  parameter int MAX_RUN      = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [TIME_BITS-1:0]            in_sample_time,
  input  logic [PAYLOAD_BITS-1:0]         in_sample_payload,
  input  logic                            in_stream_end,
  input  logic                            cfg_we,
  input  logic [nnr_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [TIME_BITS-1:0]            cfg_wdata,
  input  nnr_pkg::nnr_cmd_t               cmd,
  output nnr_pkg::nnr_sts_t               sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [TIME_BITS:0]              out_grid_time,
  output logic [TIME_BITS-1:0]            out_chosen_time,
  output logic [PAYLOAD_BITS-1:0]         out_chosen_payload,
  output logic                            out_run_last,
  output logic                            out_run_cut,
  output logic                            out_early_start
);
  localparam int TW = TIME_BITS;
  localparam int GW = TIME_BITS + 1;
  localparam int DW = TIME_BITS + 2;
  localparam int NW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  // control state
  logic          held_valid_r, held_valid_nxt;
  logic          early_r, early_nxt;
  logic          ov_r, ov_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [TW-1:0] start_r, start_nxt;
  logic [TW-1:0] step_r, step_nxt;
  logic [GW-1:0] grid_r, grid_nxt;

  // payload state
  logic [TW-1:0]           cur_t_r, cur_t_nxt;
  logic [PAYLOAD_BITS-1:0] cur_p_r, cur_p_nxt;
  logic                    cur_end_r, cur_end_nxt;
  logic [TW-1:0]           held_t_r, held_t_nxt;
  logic [PAYLOAD_BITS-1:0] held_p_r, held_p_nxt;
  logic [DW-1:0]           rem_r, rem_nxt;
  logic [DW-1:0]           lft_r, lft_nxt;
  logic [GW-1:0]           base_r, base_nxt;
  logic [GW-1:0]           og_r, og_nxt;
  logic [TW-1:0]           ot_r, ot_nxt;
  logic [PAYLOAD_BITS-1:0] op_r, op_nxt;
  logic                    olast_r, olast_nxt;
  logic                    ocut_r, ocut_nxt;
  logic                    oearly_r, oearly_nxt;

  logic [TW-1:0] step_eff;
  logic [DW-1:0] rem_after;
  logic          after_neg;
  logic          at_max;
  logic          take_left;
  logic          slot_free;
  logic          div_busy;
  logic [TW-1:0] div_rem;

  assign step_eff  = (step_r == '0) ? TW'(1) : step_r;
  assign rem_after = rem_r - {2'b00, step_eff};
  assign after_neg = rem_after[DW-1];
  assign at_max    = (n_r == NW'(MAX_RUN - 1));
  // a grid time before the held sample always takes the arriving one
  assign take_left = !lft_r[DW-1] && ($signed(lft_r) <= $signed(rem_r));
  assign slot_free = !ov_r || out_ready;

  nnr_rem #(.W(TW)) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (rem_r[TW-1:0]),
    .divisor  (step_eff),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  always_comb begin
    held_valid_nxt = held_valid_r;
    early_nxt      = early_r;
    ov_nxt         = ov_r;
    n_nxt          = n_r;
    start_nxt      = start_r;
    step_nxt       = step_r;
    grid_nxt       = grid_r;
    cur_t_nxt      = cur_t_r;
    cur_p_nxt      = cur_p_r;
    cur_end_nxt    = cur_end_r;
    held_t_nxt     = held_t_r;
    held_p_nxt     = held_p_r;
    rem_nxt        = rem_r;
    lft_nxt        = lft_r;
    base_nxt       = base_r;
    og_nxt         = og_r;
    ot_nxt         = ot_r;
    op_nxt         = op_r;
    olast_nxt      = olast_r;
    ocut_nxt       = ocut_r;
    oearly_nxt     = oearly_r;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    if (cmd.load_in) begin
      cur_t_nxt   = in_sample_time;
      cur_p_nxt   = in_sample_payload;
      cur_end_nxt = in_stream_end;
    end

    if (cmd.setup) begin
      if (!held_valid_r) begin
        early_nxt = (grid_r < {1'b0, cur_t_r});
      end
      rem_nxt = {2'b00, cur_t_r} - {1'b0, grid_r};
      lft_nxt = {1'b0, grid_r} - {2'b00, held_t_r};
      n_nxt   = '0;
    end

    if (cmd.emit_one) begin
      ov_nxt     = 1'b1;
      og_nxt     = grid_r;
      ot_nxt     = cur_t_r;
      op_nxt     = cur_p_r;
      olast_nxt  = 1'b1;
      ocut_nxt   = 1'b0;
      oearly_nxt = early_r;
    end

    if (cmd.emit_run) begin
      ov_nxt     = 1'b1;
      og_nxt     = grid_r;
      ot_nxt     = take_left ? held_t_r : cur_t_r;
      op_nxt     = take_left ? held_p_r : cur_p_r;
      olast_nxt  = at_max || after_neg;
      ocut_nxt   = at_max && !after_neg;
      oearly_nxt = early_r;
      grid_nxt   = grid_r + {1'b0, step_eff};
      rem_nxt    = rem_after;
      lft_nxt    = lft_r + {2'b00, step_eff};
      n_nxt      = n_r + 1'b1;
    end

    if (cmd.div_go) begin
      base_nxt = {1'b0, cur_t_r} + {1'b0, step_eff};
    end

    // first grid time past the sample: t + step - (t - g) mod step
    if (cmd.fix) begin
      grid_nxt = base_r - {1'b0, div_rem};
    end

    if (cmd.commit) begin
      if (cur_end_r) begin
        held_valid_nxt = 1'b0;
        grid_nxt       = {1'b0, start_r};
        early_nxt      = 1'b0;
      end else begin
        held_valid_nxt = 1'b1;
        held_t_nxt     = cur_t_r;
        held_p_nxt     = cur_p_r;
      end
    end

    if (cfg_we) begin
      unique case (cfg_idx)
        nnr_pkg::CFG_START: begin
          start_nxt = cfg_wdata;
          if (!held_valid_r) begin
            grid_nxt = {1'b0, cfg_wdata};
          end
        end
        nnr_pkg::CFG_STEP: begin
          step_nxt = cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      early_r      <= 1'b0;
      ov_r         <= 1'b0;
      n_r          <= '0;
      start_r      <= '0;
      step_r       <= TW'(nnr_pkg::STEP_RESET);
      grid_r       <= '0;
    end else begin
      held_valid_r <= held_valid_nxt;
      early_r      <= early_nxt;
      ov_r         <= ov_nxt;
      n_r          <= n_nxt;
      start_r      <= start_nxt;
      step_r       <= step_nxt;
      grid_r       <= grid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_t_r   <= cur_t_nxt;
    cur_p_r   <= cur_p_nxt;
    cur_end_r <= cur_end_nxt;
    held_t_r  <= held_t_nxt;
    held_p_r  <= held_p_nxt;
    rem_r     <= rem_nxt;
    lft_r     <= lft_nxt;
    base_r    <= base_nxt;
    og_r      <= og_nxt;
    ot_r      <= ot_nxt;
    op_r      <= op_nxt;
    olast_r   <= olast_nxt;
    ocut_r    <= ocut_nxt;
    oearly_r  <= oearly_nxt;
  end

  always_comb begin
    sts            = '0;
    sts.held_valid = held_valid_r;
    sts.cur_end    = cur_end_r;
    sts.slot_free  = slot_free;
    sts.run_empty  = rem_r[DW-1];
    sts.run_last   = at_max || after_neg;
    sts.run_cut    = at_max && !after_neg;
    sts.div_busy   = div_busy;
  end

  assign out_valid          = ov_r;
  assign out_grid_time      = og_r;
  assign out_chosen_time    = ot_r;
  assign out_chosen_payload = op_r;
  assign out_run_last       = olast_r;
  assign out_run_cut        = ocut_r;
  assign out_early_start    = oearly_r;

endmodule

/* sv/nnr_ctrl.sv */
// resampler controller: sequences accept, single results, run emission and grid skip
`timescale 1ns / 1ps

module nnr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nnr_pkg::nnr_sts_t sts,
  output nnr_pkg::nnr_cmd_t cmd
);
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SETUP   = 3'd1;
  localparam logic [2:0] S_ONE     = 3'd2;
  localparam logic [2:0] S_RUN     = 3'd3;
  localparam logic [2:0] S_DIVGO   = 3'd4;
  localparam logic [2:0] S_DIVWAIT = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.held_valid) begin
          state_nxt = S_RUN;
        end else if (sts.cur_end) begin
          state_nxt = S_ONE;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_ONE: begin
        if (sts.slot_free) begin
          cmd.emit_one = 1'b1;
          cmd.commit   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RUN: begin
        if (sts.run_empty) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end else if (sts.slot_free) begin
          cmd.emit_run = 1'b1;
          if (sts.run_last) begin
            // a closing stream resets the grid, so skip placement is moot
            if (sts.run_cut && !sts.cur_end) begin
              state_nxt = S_DIVGO;
            end else begin
              cmd.commit = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
        end
      end
      S_DIVGO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (!sts.div_busy) begin
          cmd.fix    = 1'b1;
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/nnr_checker.sv */
// port-level assertions of the resampler and their bind
`timescale 1ns / 1ps

module nnr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic run_last,
  input logic run_cut
);

  // a result waiting for the sink stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a cut flag only closes a run
  a_cut_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && run_cut |-> run_last)
    else $error("run_cut without run_last");

  // a taken word is worked on before the next one
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  // reset leaves no result behind
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nearest_neighbor_resampler nnr_checker u_nnr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .run_last  (out_ch.run_last),
  .run_cut   (out_ch.run_cut)
);

/* tb/sv/nearest_neighbor_resampler_tb.sv */
// self-checking testbench of the nearest neighbor resampler: directed and random sample streams
`timescale 1ns / 1ps

module nearest_neighbor_resampler_tb;

  localparam int TIME_BITS    = 32;
  localparam int PAYLOAD_BITS = 64;
  localparam int MAX_RUN_LEN  = 64;

  // the block ignores writes to indexes past step_time
  localparam logic [nnr_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  localparam logic [63:0] GRID_MASK  = 64'h1_FFFF_FFFF;
  localparam logic [31:0] TIME_MAX   = 32'hFFFF_FFFF;
  localparam int RANDOM_WORDS        = 300;
  localparam int NORMAL_IDLE_PCT     = 25;
  localparam int MAX_REPORTS         = 10;
  // a cut run places the grid serially after its last result
  localparam int DRAIN_CYCLES        = 80;

  // one resampled grid point as it leaves the block
  typedef struct packed {
    logic [TIME_BITS:0]      grid;
    logic [TIME_BITS-1:0]    chosen_time;
    logic [PAYLOAD_BITS-1:0] chosen_payload;
    logic                    last;
    logic                    cut;
    logic                    early;
  } grid_point_t;

  // mirrors the resampler state and keeps the grid points still owed by the block
  class resample_tracker;
    grid_point_t owed[$];
    int failures;
    logic [31:0] start_reg;
    logic [31:0] step_reg;
    logic [31:0] prior_time;
    logic [63:0] prior_payload;
    bit          prior_held;
    logic [32:0] grid_next;
    bit          early_flag;

    function new();
      start_reg = '0;
      step_reg  = 32'(nnr_pkg::STEP_RESET);
      failures  = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      prior_time    = '0;
      prior_payload = '0;
      prior_held    = 1'b0;
      grid_next     = {1'b0, start_reg};
      early_flag    = 1'b0;
    endfunction

    function void write_reg(logic [nnr_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] value);
      if (idx == nnr_pkg::CFG_START) begin
        start_reg = value;
        // during a stream the new start waits for the next stream
        if (!prior_held) grid_next = {1'b0, value};
      end else if (idx == nnr_pkg::CFG_STEP) begin
        step_reg = value;
      end
    endfunction

    // accepted sample word: queue the grid points it serves
    function void take_sample(logic [31:0] t, logic [63:0] p, logic fin);
      grid_point_t pt;
      logic [63:0] stride, g, t64, k;
      bit cut;
      int n;
      stride = (step_reg == 0) ? 64'd1 : 64'(step_reg);
      t64    = 64'(t);
      cut    = 1'b0;
      n      = 0;
      pt     = '0;
      if (!prior_held) begin
        early_flag = (64'(grid_next) < t64);
        if (fin) begin
          // lone sample serves the start of the grid itself
          pt.grid           = grid_next;
          pt.chosen_time    = t;
          pt.chosen_payload = p;
          pt.last           = 1'b1;
          pt.early          = early_flag;
          owed = {owed, pt};
          clear_stream();
        end else begin
          prior_time    = t;
          prior_payload = p;
          prior_held    = 1'b1;
        end
        return;
      end
      g = 64'(grid_next);
      while (g <= t64 && n < MAX_RUN_LEN) begin
        pt.grid  = g[32:0];
        pt.early = early_flag;
        // grid before the held sample, or strictly closer to the new one: take the new one
        if (g >= 64'(prior_time) && (g - 64'(prior_time)) <= (t64 - g)) begin
          pt.chosen_time    = prior_time;
          pt.chosen_payload = prior_payload;
        end else begin
          pt.chosen_time    = t;
          pt.chosen_payload = p;
        end
        owed = {owed, pt};
        n++;
        g = (g + stride) & GRID_MASK;
      end
      if (g <= t64) begin
        // skip the grid past the sample
        k   = (t64 - g) / stride + 64'd1;
        g   = (g + k * stride) & GRID_MASK;
        cut = 1'b1;
      end
      grid_next = g[32:0];
      if (n > 0) begin
        pt      = owed.pop_back();
        pt.last = 1'b1;
        pt.cut  = cut;
        owed = {owed, pt};
      end
      prior_time    = t;
      prior_payload = p;
      if (fin) clear_stream();
    endfunction

    function void check_point(grid_point_t got);
      grid_point_t want;
      if (owed.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected grid point: grid %h time %h payload %h last %b cut %b early %b",
                   got.grid, got.chosen_time, got.chosen_payload, got.last, got.cut, got.early);
        return;
      end
      want = owed.pop_front();
      if (got.grid !== want.grid || got.chosen_time !== want.chosen_time ||
          got.chosen_payload !== want.chosen_payload || got.last !== want.last ||
          got.cut !== want.cut || got.early !== want.early) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("grid point mismatch: want grid %h time %h payload %h last %b cut %b early %b",
                   want.grid, want.chosen_time, want.chosen_payload, want.last, want.cut,
                   want.early);
          $display("                      got  grid %h time %h payload %h last %b cut %b early %b",
                   got.grid, got.chosen_time, got.chosen_payload, got.last, got.cut, got.early);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [nnr_pkg::CFG_IDX_BITS-1:0] cfg_idx;
  logic [TIME_BITS-1:0] cfg_wdata;

  // percent of cycles in which each side holds off; zero during the busy stretch
  int idle_pct = NORMAL_IDLE_PCT;
  int sent_words = 0;

  resample_tracker book = new();

  nnr_in_if  #(.TIME_BITS(TIME_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) in_ch ();
  nnr_out_if #(.TIME_BITS(TIME_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) out_ch ();

  nearest_neighbor_resampler #(
    .TIME_BITS(TIME_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .MAX_RUN(MAX_RUN_LEN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // saturate a stepped timestamp at the top of the time range
  function automatic logic [31:0] clip_time(logic [63:0] v);
    return (v > 64'(TIME_MAX)) ? TIME_MAX : v[31:0];
  endfunction

  // offer one sample word; valid stays high afterwards unless the next word idles first
  task automatic send_sample(input logic [31:0] t, input logic [63:0] p, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.sample_time    <= t;
    in_ch.sample_payload <= p;
    in_ch.stream_end     <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    book.take_sample(t, p, fin);
    sent_words++;
  endtask

  // hold the sender until every owed grid point is back, then let a skip finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (book.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write enable stays high; the caller lowers it after its last write
  task automatic write_cfg(input logic [nnr_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    book.write_reg(idx, value);
  endtask

  // result side: check each accepted word, then pick the next ready at random
  initial begin : drain_results
    grid_point_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.grid           = out_ch.grid_time;
        got.chosen_time    = out_ch.chosen_time;
        got.chosen_payload = out_ch.chosen_payload;
        got.last           = out_ch.run_last;
        got.cut            = out_ch.run_cut;
        got.early          = out_ch.early_start;
        book.check_point(got);
      end
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin : stimulus
    logic [63:0] nt, stride;
    logic [31:0] t, start_pick, step_pick;
    logic fin;
    int len, first_random, streams;

    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= nnr_pkg::CFG_START;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.sample_time    <= '0;
    in_ch.sample_payload <= '0;
    in_ch.stream_end     <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset grid: start 0, step 5
    // lone samples at both ends of the time range, on time and late
    send_sample(32'd0, 64'd0, 1'b1);
    send_sample(TIME_MAX, '1, 1'b1);

    // first sample after the grid start, then a descending one: all grid points go to it
    send_sample(32'd20, 64'h5555_5555_5555_5555, 1'b0);
    send_sample(32'd10, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_sample(32'd13, 64'h0123_4567_89AB_CDEF, 1'b0);
    // grid 15 is equally far from 13 and 17: the earlier sample wins
    send_sample(32'd17, 64'hFEDC_BA98_7654_3210, 1'b0);
    // long gap: run cut at the limit, grid skipped past the sample
    send_sample(32'd1000, {$urandom, $urandom}, 1'b0);
    send_sample(32'd1006, {$urandom, $urandom}, 1'b1);

    // grid at the top of the range; the next grid point falls beyond it
    settle();
    write_cfg(CFG_UNUSED, $urandom);
    write_cfg(nnr_pkg::CFG_START, 32'hFFFF_FFF0);
    write_cfg(nnr_pkg::CFG_STEP, TIME_MAX);
    cfg_we <= 1'b0;
    send_sample(32'd0, {$urandom, $urandom}, 1'b0);
    send_sample(TIME_MAX, {$urandom, $urandom}, 1'b0);
    send_sample(TIME_MAX, {$urandom, $urandom}, 1'b1);

    // unit step: long run cut at the limit, then closed by the end of the stream
    settle();
    write_cfg(nnr_pkg::CFG_START, 32'd100);
    write_cfg(nnr_pkg::CFG_STEP, 32'd1);
    cfg_we <= 1'b0;
    send_sample(32'd50, {$urandom, $urandom}, 1'b0);
    send_sample(32'd500, {$urandom, $urandom}, 1'b1);

    // start moved while a sample is held: only the next stream sees it
    send_sample(32'd10, {$urandom, $urandom}, 1'b0);
    settle();
    write_cfg(nnr_pkg::CFG_START, 32'd0);
    cfg_we <= 1'b0;
    send_sample(32'd120, {$urandom, $urandom}, 1'b0);
    send_sample(32'd121, {$urandom, $urandom}, 1'b1);
    send_sample(32'd5, {$urandom, $urandom}, 1'b1);

    // random streams, grid retuned every few streams
    first_random = sent_words;
    streams = 0;
    t = '0;
    while (sent_words - first_random < RANDOM_WORDS) begin
      if (streams % 4 == 0) begin
        case ($urandom_range(4))
          0:       start_pick = '0;
          1:       start_pick = $urandom_range(0, 200);
          2:       start_pick = $urandom;
          3:       start_pick = TIME_MAX;
          default: start_pick = 32'hFFFF_FF00 | $urandom_range(0, 255);
        endcase
        case ($urandom_range(5))
          0:       step_pick = 32'd1;
          2:       step_pick = $urandom_range(17, 1000);
          3:       step_pick = $urandom;
          4:       step_pick = TIME_MAX;
          default: step_pick = $urandom_range(2, 16);
        endcase
        if (step_pick == 0) step_pick = 32'd1;
        settle();
        if ($urandom_range(2) == 0) write_cfg(CFG_UNUSED, $urandom);
        write_cfg(nnr_pkg::CFG_START, start_pick);
        write_cfg(nnr_pkg::CFG_STEP, step_pick);
        cfg_we <= 1'b0;
      end else if ($urandom_range(7) == 0) begin
        // lone start write, sometimes with a stream still open
        settle();
        write_cfg(nnr_pkg::CFG_START,
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 500));
        cfg_we <= 1'b0;
      end
      streams++;

      stride = 64'(book.step_reg);
      case ($urandom_range(4))
        0:       nt = 64'(book.start_reg);
        1:       nt = 64'(book.start_reg) + $urandom_range(0, 40);
        2:       nt = (book.start_reg > 40) ? 64'(book.start_reg) - $urandom_range(1, 40) : 0;
        3:       nt = 64'($urandom);
        default: nt = 64'(TIME_MAX) - $urandom_range(0, 3);
      endcase
      t = clip_time(nt);
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        // no holding off in the middle of the random part
        if (sent_words - first_random >= 100 && sent_words - first_random < 160)
          idle_pct = 0;
        else
          idle_pct = NORMAL_IDLE_PCT;
        // most streams end properly, some run on into the next one
        fin = (i == len - 1) && ($urandom_range(99) < 85);
        send_sample(t, {$urandom, $urandom}, fin);
        case ($urandom_range(99)) inside
          [0:79]:  nt = 64'(t) + ({$urandom, $urandom} % (2 * stride + 1));
          [80:85]: nt = 64'(t) + stride * $urandom_range(65, 160);
          [86:91]: nt = 64'(t);
          [92:95]: nt = (t > 32'd64) ? 64'(t) - $urandom_range(1, 64) : 64'd0;
          default: nt = 64'($urandom);
        endcase
        t = clip_time(nt);
      end
    end
    idle_pct = NORMAL_IDLE_PCT;

    settle();
    if (book.failures == 0 && book.owed.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
